>>> src/sspr_pkg.sv
// Shared types and constants for the servo status packet receiver.
`timescale 1ns / 1ps
package sspr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HEADER   = 3'd1,
    PH_PREAMBLE = 3'd2,
    PH_DATA     = 3'd3,
    PH_TIMEOUT  = 3'd4
  } phase_t;

  localparam logic [2:0] EV_PARAM    = 3'd0;
  localparam logic [2:0] EV_GOOD     = 3'd1;
  localparam logic [2:0] EV_CRC_BAD  = 3'd2;
  localparam logic [2:0] EV_TIMEOUT  = 3'd3;
  localparam logic [2:0] EV_BAD_LEN  = 3'd4;

  localparam logic REG_PER_BYTE = 1'b0;
  localparam logic REG_PACKET   = 1'b1;

  localparam logic [7:0] HDR_FF = 8'hFF;
  localparam logic [7:0] HDR_FD = 8'hFD;
  localparam logic [7:0] HDR_00 = 8'h00;
  localparam logic [11:0] SLACK_US = 12'd2000;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // Beat passed from the front end to the frame engine.
  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
  } beat_t;

  // Result beat.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  param_byte;
    logic [7:0]  device_id;
    logic [7:0]  instruction_code;
    logic [7:0]  device_error;
    logic [15:0] param_count;
    logic        last;
  } result_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> src/sspr_fifo.sv
// Small register queue used between the stages and at the output.
`timescale 1ns / 1ps
module sspr_fifo #(
  parameter int WIDTH = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] mem [2];
  logic             wptr, rptr;
  logic [1:0]       count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      count <= count + 2'(wr && !full) - 2'(rd && !empty);
    end
  end
endmodule

>>> src/sspr_engine.sv
// Frame engine: header hunt, field capture, CRC, timeouts.
`timescale 1ns / 1ps
module sspr_engine #(
  parameter int TIMER_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [9:0]          byte_budget_us,
  input  logic [15:0]         packet_wait_us,
  input  logic                in_valid,
  input  sspr_pkg::beat_t     in_beat,
  output logic                in_ready,
  output logic                out_valid,
  output sspr_pkg::result_t   out_res,
  input  logic                out_full
);
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;
  localparam int PW = 27; // width of the per-byte budget times length product

  sspr_pkg::phase_t phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [16:0] bytes_taken, bytes_taken_next;
  logic [15:0] length_field, length_field_next;
  logic [7:0]  frame_id, frame_id_next, frame_instruction, frame_instruction_next;
  logic [7:0]  frame_error, frame_error_next;
  logic [15:0] crc_acc, crc_acc_next, received_crc, received_crc_next;
  logic [TIMER_WIDTH-1:0] elapsed, elapsed_next, limit, limit_next;
  logic        emit;
  logic [2:0]  emit_kind;
  logic [7:0]  emit_byte;
  logic [15:0] crc_in;
  logic [7:0]  hdr_expect;
  logic [PW-1:0] prod;
  logic [PW+1:0] pre_sum, data_sum;
  logic [TIMER_WIDTH-1:0] pkt_lim, pre_lim, data_lim;

  // Stall the whole step while the output queue is full.
  assign in_ready = !out_full;
  wire go = in_valid && in_ready;

  function automatic logic [TIMER_WIDTH-1:0] sat(input logic [PW+1:0] v);
    if (TIMER_WIDTH >= PW + 2) return TIMER_WIDTH'(v);
    else if ((v >> TIMER_WIDTH) != '0) return TMAX;
    else return TIMER_WIDTH'(v);
  endfunction

  always_comb begin
    prod     = PW'(byte_budget_us) * PW'(length_field_next);
    pre_sum  = (PW+2)'(byte_budget_us) * (PW+2)'(5) + (PW+2)'(sspr_pkg::SLACK_US)
             + (PW+2)'(packet_wait_us);
    data_sum = (PW+2)'(prod) + (PW+2)'(sspr_pkg::SLACK_US) + (PW+2)'(packet_wait_us);
    pkt_lim  = sat((PW+2)'(packet_wait_us));
    pre_lim  = sat(pre_sum);
    data_lim = sat(data_sum);
    case (header_index[1:0])
      2'd0, 2'd1: hdr_expect = sspr_pkg::HDR_FF;
      2'd2:       hdr_expect = sspr_pkg::HDR_FD;
      default:    hdr_expect = sspr_pkg::HDR_00;
    endcase
  end

  always_comb begin
    phase_next = phase;
    header_index_next = header_index;
    bytes_taken_next = bytes_taken;
    length_field_next = length_field;
    frame_id_next = frame_id;
    frame_instruction_next = frame_instruction;
    frame_error_next = frame_error;
    crc_acc_next = crc_acc;
    received_crc_next = received_crc;
    elapsed_next = elapsed;
    limit_next = limit;
    emit = 1'b0;
    emit_kind = sspr_pkg::EV_PARAM;
    emit_byte = 8'h00;
    crc_in = crc_acc;
    if (in_beat.is_tick) begin
      if (elapsed != TMAX) elapsed_next = elapsed + 1'b1;
      if ((phase == sspr_pkg::PH_HEADER || phase == sspr_pkg::PH_PREAMBLE ||
           phase == sspr_pkg::PH_DATA) && !(elapsed_next < limit)) begin
        phase_next = sspr_pkg::PH_TIMEOUT;
        emit = 1'b1;
        emit_kind = sspr_pkg::EV_TIMEOUT;
      end
    end else begin
      case (phase)
        sspr_pkg::PH_IDLE: begin
          if (in_beat.data == sspr_pkg::HDR_FF) begin
            length_field_next = '0;
            frame_id_next = '0;
            frame_instruction_next = '0;
            frame_error_next = '0;
            received_crc_next = '0;
            crc_in = '0;
            crc_acc_next = sspr_pkg::crc_step(crc_in, in_beat.data);
            header_index_next = 3'd1;
            bytes_taken_next = '0;
            phase_next = sspr_pkg::PH_HEADER;
            elapsed_next = '0;
            limit_next = pkt_lim;
          end
        end
        sspr_pkg::PH_HEADER: begin
          if (in_beat.data == hdr_expect) begin
            crc_acc_next = sspr_pkg::crc_step(crc_acc, in_beat.data);
            if (header_index == 3'd3) begin
              header_index_next = '0;
              bytes_taken_next = '0;
              phase_next = sspr_pkg::PH_PREAMBLE;
              elapsed_next = '0;
              limit_next = pre_lim;
            end else begin
              header_index_next = header_index + 3'd1;
            end
          end
        end
        sspr_pkg::PH_PREAMBLE: begin
          crc_acc_next = sspr_pkg::crc_step(crc_acc, in_beat.data);
          case (bytes_taken[2:0])
            3'd0: frame_id_next = in_beat.data;
            3'd1: length_field_next = {8'h00, in_beat.data};
            3'd2: length_field_next = {in_beat.data, length_field[7:0]};
            3'd3: frame_instruction_next = in_beat.data;
            default: frame_error_next = in_beat.data;
          endcase
          bytes_taken_next = bytes_taken + 17'd1;
          if (bytes_taken == 17'd4) begin
            if (length_field < 16'd4) begin
              phase_next = sspr_pkg::PH_IDLE;
              header_index_next = '0;
              bytes_taken_next = '0;
              emit = 1'b1;
              emit_kind = sspr_pkg::EV_BAD_LEN;
            end else begin
              phase_next = sspr_pkg::PH_DATA;
              limit_next = data_lim;
            end
          end
        end
        sspr_pkg::PH_DATA: begin
          if (bytes_taken <= {1'b0, length_field}) begin
            crc_acc_next = sspr_pkg::crc_step(crc_acc, in_beat.data);
            bytes_taken_next = bytes_taken + 17'd1;
            emit = 1'b1;
            emit_kind = sspr_pkg::EV_PARAM;
            emit_byte = in_beat.data;
          end else if (bytes_taken == {1'b0, length_field} + 17'd1) begin
            received_crc_next = {8'h00, in_beat.data};
            bytes_taken_next = bytes_taken + 17'd1;
          end else begin
            received_crc_next = {in_beat.data, received_crc[7:0]};
            phase_next = sspr_pkg::PH_IDLE;
            header_index_next = '0;
            bytes_taken_next = '0;
            emit = 1'b1;
            emit_kind = (received_crc_next == crc_acc) ? sspr_pkg::EV_GOOD
                                                       : sspr_pkg::EV_CRC_BAD;
          end
        end
        default: begin
          phase_next = sspr_pkg::PH_IDLE;
          header_index_next = '0;
          bytes_taken_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid = go && emit;
    out_res.kind = emit_kind;
    out_res.param_byte = emit_byte;
    out_res.device_id = frame_id_next;
    out_res.instruction_code = frame_instruction_next;
    out_res.device_error = frame_error_next;
    out_res.param_count = (length_field_next >= 16'd4) ? length_field_next - 16'd4 : 16'd0;
    out_res.last = emit_kind != sspr_pkg::EV_PARAM;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sspr_pkg::PH_IDLE;
      header_index <= '0;
      bytes_taken <= '0;
      length_field <= '0;
      frame_id <= '0;
      frame_instruction <= '0;
      frame_error <= '0;
      crc_acc <= '0;
      received_crc <= '0;
      elapsed <= '0;
      limit <= '0;
    end else if (go) begin
      phase <= phase_next;
      header_index <= header_index_next;
      bytes_taken <= bytes_taken_next;
      length_field <= length_field_next;
      frame_id <= frame_id_next;
      frame_instruction <= frame_instruction_next;
      frame_error <= frame_error_next;
      crc_acc <= crc_acc_next;
      received_crc <= received_crc_next;
      elapsed <= elapsed_next;
      limit <= limit_next;
    end
  end
endmodule

>>> src/servo_status_packet_receiver_top.sv
// Top level of the servo status packet receiver.
// Usage:
//   Input queue: drive opcode/rx_byte with push while full is low. opcode 0
//   is a received serial byte, opcode 1 a one-microsecond tick.
//   Output queue: while empty is low a result sits on event_kind and the
//   frame fields; pop takes it. Kind 0 carries one parameter byte, kinds 1
//   to 4 end a frame with last set.
//   Config: cfg_we/cfg_index/cfg_data write the per-byte budget (0) and
//   packet_wait_us (1); write only while idle.
// Path: a beat passes a two-entry input queue, then the frame engine
//   computes its whole update combinationally (one CRC byte step, one 10x16
//   multiply for the data-phase budget), and a result is written into a
//   two-entry output queue, which lowers empty.
// Throughput: one beat per cycle while pop keeps up.
// Reset (rst, synchronous) empties both queues and returns to header hunt.
// If pop is held low the output queue fills, the engine stalls, then the
//   input queue fills and full rises; no beat is lost.
`timescale 1ns / 1ps
module servo_status_packet_receiver_top #(
  parameter int TIMER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_kind,
  output logic [7:0]  param_byte,
  output logic [7:0]  device_id,
  output logic [7:0]  instruction_code,
  output logic [7:0]  device_error,
  output logic [15:0] param_count,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [9:0]  byte_budget_us;
  logic [15:0] packet_wait_us;
  sspr_pkg::beat_t   q_beat;
  sspr_pkg::result_t e_res, o_res;
  logic q_empty, e_ready, e_valid, o_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_budget_us <= '0;
      packet_wait_us <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sspr_pkg::REG_PER_BYTE: byte_budget_us <= cfg_data[9:0];
        default:                packet_wait_us <= cfg_data;
      endcase
    end
  end

  sspr_fifo #(.WIDTH($bits(sspr_pkg::beat_t))) u_in (
    .clk, .rst, .wr(push), .wdata({opcode, rx_byte}), .full,
    .rd(e_ready), .rdata(q_beat), .empty(q_empty)
  );

  sspr_engine #(.TIMER_WIDTH(TIMER_WIDTH)) u_eng (
    .clk, .rst, .byte_budget_us, .packet_wait_us,
    .in_valid(!q_empty), .in_beat(q_beat), .in_ready(e_ready),
    .out_valid(e_valid), .out_res(e_res), .out_full(o_full)
  );

  sspr_fifo #(.WIDTH($bits(sspr_pkg::result_t))) u_out (
    .clk, .rst, .wr(e_valid), .wdata(e_res), .full(o_full),
    .rd(pop), .rdata(o_res), .empty
  );

  assign event_kind = o_res.kind;
  assign param_byte = o_res.param_byte;
  assign device_id = o_res.device_id;
  assign instruction_code = o_res.instruction_code;
  assign device_error = o_res.device_error;
  assign param_count = o_res.param_count;
  assign last = o_res.last;

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (event_kind != sspr_pkg::EV_PARAM)))
    else $error("last flag disagrees with kind");
  a_param_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (param_byte == 8'h00))
    else $error("frame end carries a parameter byte");
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> !o_full)
    else $error("result written into a full queue");
endmodule
